@@ rtl/etl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_pkg: shared types and constants of the expression token lexer
// Request and result records, the bundle of results one character makes,
// character codes, token kinds, error codes and sizing constants.
// ----------------------------------------------------------------------------
package etl_pkg;

    // sizing
    localparam int MAX_TOKEN_LENGTH = 8191;
    localparam int DEPTH_BITS       = 16;
    localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int TOKEN_LEN_W      = 13;
    localparam int MAX_RESULTS      = 4;
    localparam int SUB_W            = $clog2(MAX_RESULTS);
    localparam int CNT_W            = SUB_W + 1;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    // record kinds
    localparam logic [1:0] REC_CHAR     = 2'd0;
    localparam logic [1:0] REC_COMPLETE = 2'd1;
    localparam logic [1:0] REC_ERROR    = 2'd2;

    // token kinds
    localparam logic [3:0] TK_FUNCTION = 4'd0;
    localparam logic [3:0] TK_VARIABLE = 4'd1;
    localparam logic [3:0] TK_INTEGER  = 4'd2;
    localparam logic [3:0] TK_FLOAT    = 4'd3;
    localparam logic [3:0] TK_STRING   = 4'd4;
    localparam logic [3:0] TK_BRACKET  = 4'd5;
    localparam logic [3:0] TK_ASSIGN   = 4'd6;
    localparam logic [3:0] TK_OPERATOR = 4'd7;
    localparam logic [3:0] TK_COMMA    = 4'd8;
    localparam logic [3:0] TK_END_STMT = 4'd9;

    // error codes
    localparam logic [2:0] ERR_EXTRA_POINT   = 3'd0;
    localparam logic [2:0] ERR_STRAY_CLOSE   = 3'd1;
    localparam logic [2:0] ERR_INVALID_CHAR  = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED      = 3'd3;
    localparam logic [2:0] ERR_TOKEN_TOO_LONG = 3'd4;

    // character codes
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_OPEN       = 8'h28;
    localparam logic [7:0] CH_CLOSE      = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UPPER_LO   = 8'h41;
    localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_LO   = 8'h61;
    localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

    typedef struct packed {
        logic [7:0] char_value;
        logic       line_end;
    } t_lex_in;

    typedef struct packed {
        logic [1:0]             record_kind;
        logic [7:0]             out_char;
        logic [3:0]             token_kind;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic [2:0]             error_code;
        logic                   run_last;
    } t_lex_out;

    // all results of one character, oldest in slot 0
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_lex_out [MAX_RESULTS-1:0]      recs;
    } t_bundle;

endpackage

@@ rtl/etl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_front: character classifier and lexer state
// Takes one character per cycle while i_accept is high, advances the lexer
// mode, length and bracket depth; its results go to the queue as a bundle.
// ----------------------------------------------------------------------------
module etl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  etl_pkg::t_lex_in i_req,
    output logic             o_push,
    output etl_pkg::t_bundle o_bundle
);
    import etl_pkg::*;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_HALTED = 3'd4;

    logic [2:0]            r_mode, n_mode;
    logic                  r_dec, n_dec;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;

    function automatic t_lex_out mk_rec(logic [1:0] kind, logic [7:0] ch,
                                        logic [3:0] tk, logic [LEN_W-1:0] len,
                                        logic [2:0] err);
        t_lex_out r;
        r.record_kind  = kind;
        r.out_char     = ch;
        r.token_kind   = tk;
        r.token_length = TOKEN_LEN_W'(len);
        r.error_code   = err;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // classify the character and build its results in order
    always_comb begin
        logic [7:0]                 c;
        logic                       is_alpha;
        logic                       is_digit;
        logic                       do_idle;
        logic                       do_add;
        logic [CNT_W-1:0]           cnt;
        t_lex_out [MAX_RESULTS-1:0] recs;

        c        = i_req.char_value;
        is_alpha = (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                   (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
        is_digit = (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI);
        do_idle  = 1'b0;
        do_add   = 1'b0;
        cnt      = '0;
        recs     = '0;
        n_mode   = r_mode;
        n_dec    = r_dec;
        n_len    = r_len;
        n_depth  = r_depth;

        // mode-specific handling
        unique case (r_mode)
            MODE_IDENT: begin
                if (is_alpha || is_digit || c == CH_UNDERSCORE || c == CH_MINUS) begin
                    do_add = 1'b1;
                end else begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0,
                        (c == CH_OPEN) ? TK_FUNCTION : TK_VARIABLE, n_len, '0);
                    cnt     = cnt + 1'b1;
                    n_len   = '0;
                    n_dec   = 1'b0;
                    n_mode  = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    do_add = 1'b1;
                end else if (c == CH_POINT) begin
                    if (n_dec) begin
                        recs[cnt[SUB_W-1:0]] = mk_rec(REC_ERROR, '0, '0, '0,
                                                      ERR_EXTRA_POINT);
                        cnt    = cnt + 1'b1;
                        n_mode = MODE_HALTED;
                    end else begin
                        n_dec  = 1'b1;
                        do_add = 1'b1;
                    end
                end else begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0,
                        n_dec ? TK_FLOAT : TK_INTEGER, n_len, '0);
                    cnt     = cnt + 1'b1;
                    n_len   = '0;
                    n_dec   = 1'b0;
                    n_mode  = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_STRING,
                                                  n_len, '0);
                    cnt    = cnt + 1'b1;
                    n_len  = '0;
                    n_dec  = 1'b0;
                    n_mode = MODE_IDLE;
                end else begin
                    do_add = 1'b1;
                end
            end
            MODE_IDLE: begin
                do_idle = 1'b1;
            end
            default: begin
            end
        endcase

        // idle dispatch: start a token, emit a one-char token or an error
        if (do_idle) begin
            priority if (c == CH_SPACE) begin
            end else if (is_alpha) begin
                n_mode = MODE_IDENT;
                n_len  = '0;
                do_add = 1'b1;
            end else if (is_digit) begin
                n_mode = MODE_NUMBER;
                n_dec  = 1'b0;
                n_len  = '0;
                do_add = 1'b1;
            end else if (c == CH_QUOTE) begin
                n_mode = MODE_STRING;
                n_len  = '0;
            end else if (c == CH_CLOSE && n_depth == '0) begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_ERROR, '0, '0, '0, ERR_STRAY_CLOSE);
                cnt    = cnt + 1'b1;
                n_mode = MODE_HALTED;
            end else if (c == CH_OPEN || c == CH_CLOSE || c == CH_EQUAL ||
                         c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                         c == CH_BACKSLASH || c == CH_COMMA || c == CH_SEMI) begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_CHAR, c, '0, '0, '0);
                cnt = cnt + 1'b1;
                priority if (c == CH_OPEN || c == CH_CLOSE) begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_BRACKET,
                                                  LEN_W'(1), '0);
                end else if (c == CH_EQUAL) begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_ASSIGN,
                                                  LEN_W'(1), '0);
                end else if (c == CH_COMMA) begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_COMMA,
                                                  LEN_W'(1), '0);
                end else if (c == CH_SEMI) begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_END_STMT,
                                                  LEN_W'(1), '0);
                end else begin
                    recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0, TK_OPERATOR,
                                                  LEN_W'(1), '0);
                end
                cnt = cnt + 1'b1;
                // depth saturates going up
                if (c == CH_OPEN && n_depth != '1) begin
                    n_depth = n_depth + 1'b1;
                end else if (c == CH_CLOSE) begin
                    n_depth = n_depth - 1'b1;
                end
            end else begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_ERROR, '0, '0, '0, ERR_INVALID_CHAR);
                cnt    = cnt + 1'b1;
                n_mode = MODE_HALTED;
            end
        end

        // append a character to the open token, length checked
        if (do_add) begin
            if (n_len >= LEN_W'(MAX_TOKEN_LENGTH)) begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_ERROR, '0, '0, '0,
                                              ERR_TOKEN_TOO_LONG);
                cnt    = cnt + 1'b1;
                n_mode = MODE_HALTED;
            end else begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_CHAR, c, '0, '0, '0);
                cnt   = cnt + 1'b1;
                n_len = n_len + 1'b1;
            end
        end

        // line end: close the open token, check brackets, clear state
        if (i_req.line_end) begin
            if (n_mode == MODE_IDENT || n_mode == MODE_NUMBER ||
                n_mode == MODE_STRING) begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_COMPLETE, '0,
                    (n_mode == MODE_IDENT)  ? TK_VARIABLE :
                    (n_mode == MODE_STRING) ? TK_STRING   :
                    n_dec                   ? TK_FLOAT    : TK_INTEGER,
                    n_len, '0);
                cnt    = cnt + 1'b1;
                n_mode = MODE_IDLE;
            end
            if (n_mode != MODE_HALTED && n_depth != '0) begin
                recs[cnt[SUB_W-1:0]] = mk_rec(REC_ERROR, '0, '0, '0, ERR_UNCLOSED);
                cnt = cnt + 1'b1;
            end
            n_mode  = MODE_IDLE;
            n_dec   = 1'b0;
            n_len   = '0;
            n_depth = '0;
        end

        // mark the last result of this character
        for (int i = 0; i < MAX_RESULTS; i++) begin
            recs[i].run_last = (CNT_W'(i) == cnt - 1'b1);
        end

        o_bundle.count = cnt;
        o_bundle.recs  = recs;
        o_push         = i_accept && (cnt != '0);
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_dec   <= 1'b0;
            r_len   <= '0;
            r_depth <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_dec   <= n_dec;
            r_len   <= n_len;
            r_depth <= n_depth;
        end
    end

`ifndef SYNTHESIS
    // a line end always leaves a clean idle lexer
    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req.line_end |=> r_mode == MODE_IDLE && r_depth == '0 &&
                                       r_len == '0 && !r_dec)
        else $error("lexer state not cleared after line end");
    // a pushed bundle never exceeds the slot count
    a_bundle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_bundle.count <= CNT_W'(MAX_RESULTS))
        else $error("bundle holds too many results");
`endif

endmodule

@@ rtl/etl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_queue: bundle queue between front and back
// Small register queue of result bundles; lets the classifier keep taking
// characters while the back end drains multi-result characters.
// ----------------------------------------------------------------------------
module etl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  etl_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output etl_pkg::t_bundle o_bundle
);
    import etl_pkg::*;

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full   = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    // no push into a full queue, no pop from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full bundle queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty bundle queue");
`endif

endmodule

@@ rtl/etl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_back: result serializer and output register
// Walks the head bundle into the output register one result per cycle while
// it is empty or popped, and retires the bundle after its last result.
// ----------------------------------------------------------------------------
module etl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  etl_pkg::t_bundle  i_q_bundle,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output etl_pkg::t_lex_out o_data
);
    import etl_pkg::*;

    logic             r_valid;
    t_lex_out         r_out;
    logic [SUB_W-1:0] r_sub;
    logic             load;
    logic             last_sub;

    assign load     = i_q_valid && (!r_valid || i_pop);
    assign last_sub = ({1'b0, r_sub} == i_q_bundle.count - 1'b1);
    assign o_q_pop  = load && last_sub;
    assign o_empty  = !r_valid;
    assign o_data   = r_out;

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_q_bundle.recs[r_sub];
        end
    end

    // output valid and slot index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last_sub ? '0 : r_sub + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // slot index stays inside the head bundle
    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> {1'b0, r_sub} < i_q_bundle.count)
        else $error("result slot index beyond bundle");
`endif

endmodule

@@ rtl/expression_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_lexer: streaming expression lexer
// One character per request in, token characters, token-complete records
// and errors out, each channel handled as a queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_data (character and line-end mark) with push; a request
//   is taken at a clock edge with push high and full low.
//   Output: while empty is low the oldest result is on o_data; pop takes it.
//   A character makes zero to four results; run_last marks its final one.
// Timing:
//   The classifier takes one character per cycle while full is low. Results
//   reach o_data through the bundle queue and the output register. With pop
//   held high the back end delivers one result per cycle, so sustained rate
//   is one character per cycle while characters average at most one result;
//   a four-entry bundle queue absorbs characters that make several.
// Stall and reset:
//   With pop held low results back up into the queue and full rises; no
//   request or result is lost. Synchronous reset (i_rst_n low) empties the
//   queue and output register and returns the lexer to idle at depth zero.
// ----------------------------------------------------------------------------
module expression_token_lexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  etl_pkg::t_lex_in  i_data,
    output logic              empty,
    input  logic              pop,
    output etl_pkg::t_lex_out o_data
);
    import etl_pkg::*;

    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    t_bundle f_bundle;
    t_bundle q_bundle;

    assign accept = push && !full;

    // classifier and lexer state
    etl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_data),
        .o_push   (q_push),
        .o_bundle (f_bundle)
    );

    // bundle queue
    etl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (f_bundle),
        .o_full   (full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    // serializer and output register
    etl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_bundle (q_bundle),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_data     (o_data)
    );

endmodule

@@ test/tb_expression_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_token_lexer: self-checking bench for the expression lexer
// Streams lines of characters into the lexer and predicts every token
// character, token-complete and error record in the bench itself. Each result
// popped from the block is compared field by field with the oldest prediction.
// Covers directed lines and random well-formed and broken lines under several
// idling mixes.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer;
    import etl_pkg::*;

    localparam longint DEPTH_TOP      = (64'd1 << DEPTH_BITS) - 1;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     END_PAD        = 20;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_IDENT,
        LX_NUMBER,
        LX_STRING,
        LX_HALTED
    } t_lex_mode;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    t_lex_in  i_data  = '0;
    logic     empty;
    logic     pop     = 1'b0;
    t_lex_out o_data;

    // predicted results still to come, oldest first
    t_lex_out pending_recs[$];
    // results of the character being predicted
    t_lex_out char_recs[$];
    // characters of the line being built
    logic [7:0] line_buf[$];

    // predicted lexer state
    t_lex_mode lx_mode  = LX_IDLE;
    bit        lx_point = 1'b0;
    int        lx_len   = 0;
    longint    lx_depth = 0;

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int chars_sent    = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    expression_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_LO && c <= CH_UPPER_HI) || (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    // ------------------------------------------------------------------
    // lexer predictor
    // ------------------------------------------------------------------
    task automatic lex_note(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [3:0] tk, input int len, input logic [2:0] err);
        t_lex_out r;
        if (char_recs.size() < MAX_RESULTS) begin
            r.record_kind  = kind;
            r.out_char     = ch;
            r.token_kind   = tk;
            r.token_length = len[TOKEN_LEN_W-1:0];
            r.error_code   = err;
            r.run_last     = 1'b0;
            char_recs.push_back(r);
        end
    endtask

    task automatic lex_fault(input logic [2:0] code);
        lex_note(REC_ERROR, 8'd0, 4'd0, 0, code);
        lx_mode = LX_HALTED;
    endtask

    task automatic lex_close(input logic [3:0] tk);
        lex_note(REC_COMPLETE, 8'd0, tk, lx_len, 3'd0);
        lx_len   = 0;
        lx_point = 1'b0;
        lx_mode  = LX_IDLE;
    endtask

    // one more character of a streamed token, unless it is already at the limit
    task automatic lex_take(input logic [7:0] c);
        if (lx_len >= MAX_TOKEN_LENGTH) begin
            lex_fault(ERR_TOKEN_TOO_LONG);
        end else begin
            lex_note(REC_CHAR, c, 4'd0, 0, 3'd0);
            lx_len++;
        end
    endtask

    task automatic lex_single(input logic [7:0] c, input logic [3:0] tk);
        lex_note(REC_CHAR, c, 4'd0, 0, 3'd0);
        lex_note(REC_COMPLETE, 8'd0, tk, 1, 3'd0);
    endtask

    // character seen with no token open
    task automatic lex_start(input logic [7:0] c);
        if (c == CH_SPACE) begin
            return;
        end else if (is_letter(c)) begin
            lx_mode = LX_IDENT;
            lx_len  = 0;
            lex_take(c);
        end else if (is_digit(c)) begin
            lx_mode  = LX_NUMBER;
            lx_point = 1'b0;
            lx_len   = 0;
            lex_take(c);
        end else if (c == CH_QUOTE) begin
            lx_mode = LX_STRING;
            lx_len  = 0;
        end else if (c == CH_OPEN) begin
            if (lx_depth < DEPTH_TOP) lx_depth++;
            lex_single(c, TK_BRACKET);
        end else if (c == CH_CLOSE) begin
            if (lx_depth == 0) begin
                lex_fault(ERR_STRAY_CLOSE);
            end else begin
                lx_depth--;
                lex_single(c, TK_BRACKET);
            end
        end else if (c == CH_EQUAL) begin
            lex_single(c, TK_ASSIGN);
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_BACKSLASH) begin
            lex_single(c, TK_OPERATOR);
        end else if (c == CH_COMMA) begin
            lex_single(c, TK_COMMA);
        end else if (c == CH_SEMI) begin
            lex_single(c, TK_END_STMT);
        end else begin
            lex_fault(ERR_INVALID_CHAR);
        end
    endtask

    // predict all results of one accepted request and queue them
    task automatic lex_predict(input logic [7:0] c, input logic le);
        t_lex_out r;
        char_recs.delete();
        case (lx_mode)
            LX_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE || c == CH_MINUS) begin
                    lex_take(c);
                end else begin
                    lex_close(c == CH_OPEN ? TK_FUNCTION : TK_VARIABLE);
                    lex_start(c);
                end
            end
            LX_NUMBER: begin
                if (is_digit(c)) begin
                    lex_take(c);
                end else if (c == CH_POINT) begin
                    if (lx_point) begin
                        lex_fault(ERR_EXTRA_POINT);
                    end else begin
                        lx_point = 1'b1;
                        lex_take(c);
                    end
                end else begin
                    lex_close(lx_point ? TK_FLOAT : TK_INTEGER);
                    lex_start(c);
                end
            end
            LX_STRING: begin
                if (c == CH_QUOTE) lex_close(TK_STRING);
                else lex_take(c);
            end
            LX_IDLE: begin
                lex_start(c);
            end
            default: ;
        endcase

        // line end: close the open token, check brackets, back to clean idle
        if (le) begin
            if (lx_mode == LX_IDENT) lex_close(TK_VARIABLE);
            else if (lx_mode == LX_NUMBER) lex_close(lx_point ? TK_FLOAT : TK_INTEGER);
            else if (lx_mode == LX_STRING) lex_close(TK_STRING);
            if (lx_mode != LX_HALTED && lx_depth != 0) lex_fault(ERR_UNCLOSED);
            lx_mode  = LX_IDLE;
            lx_point = 1'b0;
            lx_len   = 0;
            lx_depth = 0;
        end

        if (char_recs.size() > 0) begin
            r = char_recs.pop_back();
            r.run_last = 1'b1;
            char_recs.push_back(r);
        end
        foreach (char_recs[i]) pending_recs.push_back(char_recs[i]);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic le);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push   <= 1'b1;
        i_data <= '{char_value: c, line_end: le};
        do @(posedge i_clk); while (full);
        lex_predict(c, le);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    // hold requests until every predicted result has been popped
    task automatic wait_results_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_recs.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // random line content
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_letter();
        if ($urandom_range(1)) return 8'($urandom_range(CH_UPPER_HI, CH_UPPER_LO));
        return 8'($urandom_range(CH_LOWER_HI, CH_LOWER_LO));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(CH_DIGIT_HI, CH_DIGIT_LO));
    endfunction

    // any byte but the closing quote
    function automatic logic [7:0] pick_content();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        return c;
    endfunction

    task automatic add_ident();
        line_buf.push_back(pick_letter());
        repeat ($urandom_range(5)) begin
            case ($urandom_range(3))
                0: line_buf.push_back(pick_letter());
                1: line_buf.push_back(pick_digit());
                2: line_buf.push_back(CH_UNDERSCORE);
                default: line_buf.push_back(CH_MINUS);
            endcase
        end
    endtask

    task automatic add_number();
        line_buf.push_back(pick_digit());
        repeat ($urandom_range(3)) line_buf.push_back(pick_digit());
        if ($urandom_range(1)) begin
            line_buf.push_back(CH_POINT);
            repeat ($urandom_range(1, 3)) line_buf.push_back(pick_digit());
            // now and then a second decimal point
            if ($urandom_range(9) == 0) line_buf.push_back(CH_POINT);
        end
    endtask

    task automatic add_string();
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(4)) line_buf.push_back(pick_content());
        if ($urandom_range(9) != 0) line_buf.push_back(CH_QUOTE);
    endtask

    // mostly well-formed expressions, some broken ones, some raw noise
    task automatic build_line();
        int depth;
        depth = 0;
        line_buf.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(10))
                    0, 1: add_ident();
                    2: begin
                        add_ident();
                        line_buf.push_back(CH_OPEN);
                        depth++;
                    end
                    3, 4: add_number();
                    5: add_string();
                    6: begin
                        if (depth > 0 || $urandom_range(9) == 0) begin
                            line_buf.push_back(CH_CLOSE);
                            if (depth > 0) depth--;
                        end
                    end
                    7: begin
                        case ($urandom_range(3))
                            0: line_buf.push_back(CH_PLUS);
                            1: line_buf.push_back(CH_MINUS);
                            2: line_buf.push_back(CH_STAR);
                            default: line_buf.push_back(CH_BACKSLASH);
                        endcase
                    end
                    8: begin
                        line_buf.push_back(CH_OPEN);
                        depth++;
                    end
                    9: begin
                        case ($urandom_range(2))
                            0: line_buf.push_back(CH_EQUAL);
                            1: line_buf.push_back(CH_COMMA);
                            default: line_buf.push_back(CH_SEMI);
                        endcase
                    end
                    default: line_buf.push_back(CH_SPACE);
                endcase
                if ($urandom_range(2) == 0) line_buf.push_back(CH_SPACE);
            end
            // usually balance the brackets, sometimes leave some open
            while (depth > 0 && $urandom_range(9) != 0) begin
                line_buf.push_back(CH_CLOSE);
                depth--;
            end
        end
        if (line_buf.size() == 0) line_buf.push_back(CH_SPACE);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_lines();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        // every token kind but function and bracket, every operator but plus
        add_text("a=1.5*2\\-3,\"s\";");
        send_line();
        // function call with identifier using underscore and minus
        add_text("f(x_1-Z)");
        send_line();
        // function name closed by a '(' that ends the line: unclosed bracket
        add_text("g(");
        send_line();
        // stray close bracket, rest of line ignored
        add_text(")(");
        send_line();
        // second decimal point
        add_text("7..");
        send_line();
        // string still open at line end, identifier open at line end
        add_text("\"ab");
        send_line();
        add_text("b9");
        send_line();
        // lone point, NUL and top byte are invalid
        send_char(CH_POINT, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_random_lines(input int send_pct, input int stall_pct, input int n_chars);
        int  start;
        bit  paused;
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        start  = chars_sent;
        paused = 1'b0;
        while (chars_sent - start < n_chars) begin
            build_line();
            send_line();
            if (!paused && chars_sent - start >= n_chars / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare each popped result with the oldest prediction
    always @(posedge i_clk) begin
        t_lex_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_recs.size() == 0) begin
                $error("result with nothing expected: record_kind %0d out_char %0d",
                       o_data.record_kind, o_data.out_char);
                fail_count++;
            end else begin
                want = pending_recs.pop_front();
                check_field("record_kind", want.record_kind, o_data.record_kind);
                check_field("out_char", want.out_char, o_data.out_char);
                check_field("token_kind", want.token_kind, o_data.token_kind);
                check_field("token_length", want.token_length, o_data.token_length);
                check_field("error_code", want.error_code, o_data.error_code);
                check_field("run_last", want.run_last, o_data.run_last);
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_expression_token_lexer failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_random_lines(0, 0, 80);
        test_random_lines(83, 0, 80);
        test_random_lines(0, 83, 80);
        test_random_lines(24, 24, 80);

        wait_results_drained();
        repeat (END_PAD) @(posedge i_clk);

        if (fail_count == 0 && pending_recs.size() == 0) begin
            $display("tb_expression_token_lexer passed");
        end else begin
            $display("tb_expression_token_lexer failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/etl_pkg.sv
rtl/etl_front.sv
rtl/etl_queue.sv
rtl/etl_back.sv
rtl/expression_token_lexer.sv
test/tb_expression_token_lexer.sv
